// File: rtl/mexp_pkg.sv
// mexp_pkg: shared constants of the modular exponentiation unit
// holds the default word width and the configuration register indexes
// no dependencies
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int DEFAULT_WIDTH = 16;

  // configuration register indexes
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

endpackage

// File: rtl/modular_exponentiation_unit_top.sv
// modular_exponentiation_unit_top: base^exponent mod modulus, square-and-multiply
// one shared multiplier and one shift-subtract reducer under a small sequencer
// depends on mexp_pkg
//
// Usage:
//   Load the key through the write port (cfg_we, cfg_index, cfg_data): index 0 is
//   the modulus, index 1 the exponent. Both reset to 1. Write only while busy is low.
//   A base word is taken at a rising edge with start high and busy low. busy then
//   stays high until the result is out. The result appears on power_mod for exactly
//   one cycle with done high; the receiver cannot stall it, so it must take it then.
//   An exponent of zero gives 1 and a modulus of zero gives 0, both in the
//   cycle after start, without going busy.
// Sequence:
//   The base is first reduced; then each exponent bit has a decide state, a
//   multiply into the accumulator if the bit is set, and a multiply that squares.
//   Every reduction runs the shift-subtract reducer over the whole double-width
//   product, one product bit a cycle. The next start is taken in the cycle done is
//   high.
// Reset:
//   rst (synchronous, active high) returns the sequencer to idle, drops done and
//   loads the key registers with 1.
`timescale 1ns / 1ps

module modular_exponentiation_unit_top #(
  parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [WIDTH-1:0] cfg_data,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] base,
  output logic             done,
  output logic [WIDTH-1:0] power_mod
);

  localparam int CW = $clog2(2 * WIDTH);
  localparam int BW = $clog2(WIDTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RED  = 3'd3;

  localparam logic [1:0] T_BASE = 2'd0;
  localparam logic [1:0] T_ACC  = 2'd1;
  localparam logic [1:0] T_SQ   = 2'd2;

  logic [WIDTH-1:0]   modulus;
  logic [WIDTH-1:0]   exponent;
  logic [2:0]         state;
  logic [1:0]         tgt;
  logic [CW-1:0]      cnt;
  logic [BW-1:0]      bidx;
  logic [WIDTH-1:0]   esh;
  logic [WIDTH-1:0]   acc;
  logic [WIDTH-1:0]   sq;
  logic [WIDTH-1:0]   rem;
  logic [2*WIDTH-1:0] prod;

  logic [WIDTH:0]     shifted;
  logic [WIDTH:0]     sub;
  logic [WIDTH-1:0]   rem_next;
  logic [WIDTH-1:0]   mul_a;
  logic [2*WIDTH-1:0] product;

  // one restoring step of the reducer and the shared multiplier
  always_comb begin
    shifted  = {rem, prod[2*WIDTH-1]};
    sub      = shifted - {1'b0, modulus};
    rem_next = (shifted >= {1'b0, modulus}) ? sub[WIDTH-1:0] : shifted[WIDTH-1:0];
    mul_a    = (tgt == T_ACC) ? acc : sq;
    product  = (2*WIDTH)'(mul_a) * (2*WIDTH)'(sq);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WIDTH'(1);
      exponent <= WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mexp_pkg::REG_MODULUS:  modulus  <= cfg_data;
        mexp_pkg::REG_EXPONENT: exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (exponent == '0) begin
              done      <= 1'b1;
              power_mod <= WIDTH'(1);
            end else if (modulus == '0) begin
              done      <= 1'b1;
              power_mod <= '0;
            end else begin
              esh   <= exponent;
              bidx  <= '0;
              acc   <= WIDTH'(1);
              prod  <= (2*WIDTH)'(base);
              rem   <= '0;
              cnt   <= '0;
              tgt   <= T_BASE;
              state <= S_RED;
            end
          end
        end
        S_DEC: begin
          tgt   <= esh[0] ? T_ACC : T_SQ;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= product;
          rem   <= '0;
          cnt   <= '0;
          state <= S_RED;
        end
        S_RED: begin
          rem  <= rem_next;
          prod <= {prod[2*WIDTH-2:0], 1'b0};
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(2*WIDTH-1)) begin
            unique case (tgt)
              T_BASE: begin
                sq    <= rem_next;
                state <= S_DEC;
              end
              T_ACC: begin
                acc   <= rem_next;
                tgt   <= T_SQ;
                state <= S_MUL;
              end
              default: begin
                sq <= rem_next;
                if (bidx == BW'(WIDTH-1)) begin
                  done      <= 1'b1;
                  power_mod <= acc;
                  state     <= S_IDLE;
                end else begin
                  bidx  <= bidx + BW'(1);
                  esh   <= esh >> 1;
                  state <= S_DEC;
                end
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_zero_exp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && exponent == '0) |=> (done && power_mod == WIDTH'(1)))
    else $error("zero exponent did not give one");

  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    (state == S_RED) |-> (rem < modulus))
    else $error("partial remainder not below modulus");

  a_mul_to_red: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_RED && cnt == '0))
    else $error("multiply not followed by a fresh reduction");
`endif

endmodule
